@@ rtl/r16ie_pkg.sv @@
// Shared types and constants for the 16-bit instruction execute block.
`default_nettype none

package r16ie_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned RIDX_W = 3;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned CMD_W = 4;

  // LUI keeps bits 15..6 of the immediate
  localparam logic [WORD_W-1:0] LUI_MASK = 16'hFFC0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 4'd0,
    CMD_ADDI = 4'd1,
    CMD_NAND = 4'd2,
    CMD_LUI  = 4'd3,
    CMD_SW   = 4'd4,
    CMD_LW   = 4'd5,
    CMD_BEQ  = 4'd6,
    CMD_JALR = 4'd7,
    CMD_NOP  = 4'd8,
    CMD_MOVI = 4'd9
  } cmd_e;

endpackage

`default_nettype wire

@@ rtl/r16ie_in_if.sv @@
// Instruction input channel: valid/ready plus decoded instruction fields.
`default_nettype none

interface r16ie_in_if
  import r16ie_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [RIDX_W-1:0]        reg_a;
  logic [RIDX_W-1:0]        reg_b;
  logic [RIDX_W-1:0]        reg_c;
  logic signed [WORD_W-1:0] immediate;

  modport source (output valid, cmd, reg_a, reg_b, reg_c, immediate, input ready);
  modport sink   (input valid, cmd, reg_a, reg_b, reg_c, immediate, output ready);
endinterface

`default_nettype wire

@@ rtl/r16ie_out_if.sv @@
// Result output channel: valid/ready plus next PC, register write and status.
`default_nettype none

interface r16ie_out_if
  import r16ie_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] next_pc;
  logic              write_enable;
  logic [RIDX_W-1:0] write_index;
  logic [WORD_W-1:0] write_value;
  logic              status;

  modport source (output valid, next_pc, write_enable, write_index, write_value, status,
                  input ready);
  modport sink   (input valid, next_pc, write_enable, write_index, write_value, status,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/risc16_instruction_execute.sv @@
// Top level: 16-bit in-order execute unit with register file and data memory.
`default_nettype none

// Channel  | Dir | Handshake     | Item
// ---------+-----+---------------+--------------------------------------------------
// in_i     | in  | valid / ready | cmd, reg_a, reg_b, reg_c, immediate
// res_o    | out | valid / ready | next_pc, write_enable, write_index, write_value,
//          |     |               | status
//
// Flow: no new item is taken while one is in execute. The item is accepted while the
//   register file is read, executes in the next cycle (PC update, store, load address),
//   and commits once the result register can take it (register write, load data).
// Reset: after rst_ni rises, a clearing pass writes zero to all MEM_WORDS data words
//   (and the 8 registers), one word a cycle; in_i.ready stays low until the pass ends.
// Stalls: the result register holds while res_o.ready is low; the commit stage then
//   holds and no new item is taken until it drains.

module risc16_instruction_execute
  import r16ie_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  r16ie_in_if.sink   in_i,
  r16ie_out_if.source res_o
);

  localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);
  localparam logic [WORD_W:0] MEM_LIMIT = (WORD_W + 1)'(MEM_WORDS);

  // ---------------------------------------------------------------------------
  // Clearing pass after reset
  // ---------------------------------------------------------------------------
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == CLR_LAST) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------------
  logic ex_valid_q, wb_valid_q, out_valid_q;
  logic wb_go, ex_go, accept;

  // commit stage moves into the result register when that is free or draining
  assign wb_go    = wb_valid_q && (!out_valid_q || res_o.ready);
  assign ex_go    = ex_valid_q && (!wb_valid_q || wb_go);
  assign in_i.ready = !clr_busy_q && !ex_valid_q && (!wb_valid_q || wb_go);
  assign accept   = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------------
  // Register file: 2 read ports (registered), 1 write port
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] rf_mem [NUM_REGS];
  logic [WORD_W-1:0] rf_rd0_q, rf_rd1_q;
  logic [RIDX_W-1:0] rf_raddr1;
  logic              rf_we;
  logic [RIDX_W-1:0] rf_waddr;
  logic [WORD_W-1:0] rf_wdata;

  // second port serves reg_c for ADD/NAND, reg_a otherwise (store data, BEQ compare)
  assign rf_raddr1 = (in_i.cmd == CMD_ADD || in_i.cmd == CMD_NAND) ? in_i.reg_c
                                                                   : in_i.reg_a;

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (accept) begin
      rf_rd0_q <= rf_mem[in_i.reg_b];
      rf_rd1_q <= rf_mem[rf_raddr1];
    end
  end

  // ---------------------------------------------------------------------------
  // Execute stage registers
  // ---------------------------------------------------------------------------
  cmd_e              ex_cmd_q;
  logic [RIDX_W-1:0] ex_reg_a_q;
  logic [WORD_W-1:0] ex_imm_q;
  logic [WORD_W-1:0] pc_q, pc_d;

  // bypass: a commit writing the register file on the accept edge is forwarded
  logic              fwd_b_q, fwd_x_q;
  logic              fwd_b_d, fwd_x_d;
  logic [WORD_W-1:0] fwd_val_q;

  // commit stage
  logic              wb_we_q, wb_status_q, wb_load_q;
  logic [RIDX_W-1:0] wb_idx_q;
  logic [WORD_W-1:0] wb_val_q, wb_pc_q;
  logic [WORD_W-1:0] wb_wval;
  logic [WORD_W-1:0] dm_rdata_q;

  assign wb_wval = wb_load_q ? dm_rdata_q : wb_val_q;

  assign fwd_b_d = wb_go && wb_we_q && (wb_idx_q == in_i.reg_b);
  assign fwd_x_d = wb_go && wb_we_q && (wb_idx_q == rf_raddr1);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_cmd_q   <= cmd_e'(in_i.cmd);
      ex_reg_a_q <= in_i.reg_a;
      ex_imm_q   <= in_i.immediate;
      fwd_b_q    <= fwd_b_d;
      fwd_x_q    <= fwd_x_d;
      fwd_val_q  <= wb_wval;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] op_b, op_x;
  logic [WORD_W-1:0] pc_inc, mem_addr;
  logic              addr_ok;
  logic              ex_we, ex_status, ex_mem_we, ex_load;
  logic [RIDX_W-1:0] ex_widx;
  logic [WORD_W-1:0] ex_wval, ex_next_pc;

  assign op_b     = fwd_b_q ? fwd_val_q : rf_rd0_q;
  assign op_x     = fwd_x_q ? fwd_val_q : rf_rd1_q;
  assign pc_inc   = pc_q + WORD_W'(1);
  assign mem_addr = op_b + ex_imm_q;
  assign addr_ok  = {1'b0, mem_addr} < MEM_LIMIT;

  always_comb begin
    ex_we      = 1'b0;
    ex_widx    = '0;
    ex_wval    = '0;
    ex_status  = 1'b0;
    ex_mem_we  = 1'b0;
    ex_load    = 1'b0;
    ex_next_pc = pc_inc;
    case (ex_cmd_q)
      CMD_ADD: begin
        ex_we   = 1'b1;
        ex_widx = ex_reg_a_q;
        ex_wval = op_b + op_x;
      end
      CMD_ADDI: begin
        ex_we   = 1'b1;
        ex_widx = ex_reg_a_q;
        ex_wval = mem_addr;
      end
      CMD_NAND: begin
        ex_we   = 1'b1;
        ex_widx = ex_reg_a_q;
        ex_wval = ~(op_b & op_x);
      end
      CMD_LUI: begin
        ex_we   = 1'b1;
        ex_widx = ex_reg_a_q;
        ex_wval = ex_imm_q & LUI_MASK;
      end
      CMD_SW: begin
        ex_mem_we = addr_ok;
        ex_status = !addr_ok;
      end
      CMD_LW: begin
        // value arrives from data memory in the commit stage
        ex_we     = addr_ok;
        ex_widx   = addr_ok ? ex_reg_a_q : '0;
        ex_load   = addr_ok;
        ex_status = !addr_ok;
      end
      CMD_BEQ: begin
        if (op_x == op_b) begin
          ex_next_pc = pc_inc + ex_imm_q;
        end
      end
      CMD_JALR: begin
        ex_we      = 1'b1;
        ex_widx    = ex_reg_a_q;
        ex_wval    = pc_inc;
        ex_next_pc = op_b;
      end
      CMD_NOP: begin
        ex_we = 1'b1;
      end
      CMD_MOVI: begin
        ex_we   = 1'b1;
        ex_widx = ex_reg_a_q;
        ex_wval = ex_imm_q;
      end
      default: begin
      end
    endcase
  end

  assign pc_d = ex_go ? ex_next_pc : pc_q;

  // ---------------------------------------------------------------------------
  // Data memory: one port, cleared after reset
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] dm_mem [MEM_WORDS];
  logic              dm_we;
  logic [AW-1:0]     dm_waddr;
  logic [WORD_W-1:0] dm_wdata;

  assign dm_we    = clr_busy_q || (ex_go && ex_mem_we);
  assign dm_waddr = clr_busy_q ? clr_cnt_q : mem_addr[AW-1:0];
  assign dm_wdata = clr_busy_q ? '0 : op_x;

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_mem[dm_waddr] <= dm_wdata;
    end
    if (ex_go && ex_load) begin
      dm_rdata_q <= dm_mem[mem_addr[AW-1:0]];
    end
  end

  // register file write: zeroed during the clearing pass, else on commit
  assign rf_we    = clr_busy_q || (wb_go && wb_we_q);
  assign rf_waddr = clr_busy_q ? clr_cnt_q[RIDX_W-1:0] : wb_idx_q;
  assign rf_wdata = clr_busy_q ? '0 : wb_wval;

  // ---------------------------------------------------------------------------
  // Commit stage and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (ex_go) begin
      wb_we_q     <= ex_we;
      wb_idx_q    <= ex_widx;
      wb_val_q    <= ex_wval;
      wb_status_q <= ex_status;
      wb_load_q   <= ex_load;
      wb_pc_q     <= ex_next_pc;
    end
  end

  logic [WORD_W-1:0] out_pc_q, out_val_q;
  logic              out_we_q, out_status_q;
  logic [RIDX_W-1:0] out_idx_q;

  always_ff @(posedge clk_i) begin
    if (wb_go) begin
      out_pc_q     <= wb_pc_q;
      out_we_q     <= wb_we_q;
      out_idx_q    <= wb_idx_q;
      out_val_q    <= wb_wval;
      out_status_q <= wb_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
    end else begin
      pc_q <= pc_d;
      if (accept) begin
        ex_valid_q <= 1'b1;
      end else if (ex_go) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_go) begin
        wb_valid_q <= 1'b1;
      end else if (wb_go) begin
        wb_valid_q <= 1'b0;
      end
      if (wb_go) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.next_pc      = out_pc_q;
  assign res_o.write_enable = out_we_q;
  assign res_o.write_index  = out_idx_q;
  assign res_o.write_value  = out_val_q;
  assign res_o.status       = out_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_i.ready)
    else $error("item accepted during clearing pass");

  a_ex_never_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_valid_q |-> ex_go)
    else $error("execute stage stalled, operands may go stale");

  a_accept_enters_ex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ex_valid_q && !$past(ex_valid_q))
    else $error("accepted item not in execute stage");

  a_status_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status) |-> !res_o.write_enable)
    else $error("out-of-range access wrote a register");

  a_idle_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.write_enable) |->
      (res_o.write_index == '0 && res_o.write_value == '0))
    else $error("no-write result carries index or value");

endmodule

`default_nettype wire

@@ test/r16ie_exec_checker.sv @@
// Watches both channels of the execute unit, predicts each retired instruction and compares.
`timescale 1ns / 1ps

module r16ie_exec_checker
  import r16ie_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  r16ie_in_if         in_mon,
  r16ie_out_if        res_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);

  localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  typedef struct packed {
    logic [WORD_W-1:0] next_pc;
    logic              we;
    logic [RIDX_W-1:0] widx;
    logic [WORD_W-1:0] wval;
    logic              status;
  } retire_t;

  // architectural shadow state
  logic [WORD_W-1:0] arch_regs [NUM_REGS];
  logic [WORD_W-1:0] arch_mem  [MEM_WORDS];
  logic [WORD_W-1:0] arch_pc;

  retire_t     retire_q [$];
  int unsigned mismatch_cnt;

  assign mismatch_cnt_o = mismatch_cnt;
  assign pending_o      = retire_q.size();

  function automatic retire_t execute_insn(logic [CMD_W-1:0] cmd, logic [RIDX_W-1:0] ia,
                                           logic [RIDX_W-1:0] ib, logic [RIDX_W-1:0] ic,
                                           logic [WORD_W-1:0] imm);
    retire_t           r;
    logic [WORD_W-1:0] ra, rb, rc, addr;
    logic              in_range;
    ra       = arch_regs[ia];
    rb       = arch_regs[ib];
    rc       = arch_regs[ic];
    r        = '0;
    r.next_pc = arch_pc + 16'd1;
    addr     = rb + imm;
    in_range = 32'(addr) < MEM_WORDS;
    case (cmd)
      CMD_ADD: begin
        r.we = 1'b1; r.widx = ia; r.wval = rb + rc;
      end
      CMD_ADDI: begin
        r.we = 1'b1; r.widx = ia; r.wval = rb + imm;
      end
      CMD_NAND: begin
        r.we = 1'b1; r.widx = ia; r.wval = ~(rb & rc);
      end
      CMD_LUI: begin
        r.we = 1'b1; r.widx = ia; r.wval = imm & LUI_MASK;
      end
      CMD_SW: begin
        if (in_range) arch_mem[addr[AW-1:0]] = ra;
        else r.status = 1'b1;
      end
      CMD_LW: begin
        if (in_range) begin
          r.we = 1'b1; r.widx = ia; r.wval = arch_mem[addr[AW-1:0]];
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_BEQ: begin
        if (ra == rb) r.next_pc = arch_pc + 16'd1 + imm;
      end
      CMD_JALR: begin
        // link value and target both come from pre-write state
        r.we = 1'b1; r.widx = ia; r.wval = arch_pc + 16'd1; r.next_pc = rb;
      end
      CMD_NOP: begin
        r.we = 1'b1; r.widx = '0; r.wval = '0;
      end
      CMD_MOVI: begin
        r.we = 1'b1; r.widx = ia; r.wval = imm;
      end
      default: ;
    endcase
    if (r.we) arch_regs[r.widx] = r.wval;
    arch_pc = r.next_pc;
    return r;
  endfunction

  task automatic compare_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    retire_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) arch_regs[i] = '0;
      for (int i = 0; i < MEM_WORDS; i++) arch_mem[i] = '0;
      arch_pc      = '0;
      mismatch_cnt = 0;
      retire_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        retire_q.push_back(execute_insn(in_mon.cmd, in_mon.reg_a, in_mon.reg_b,
                                        in_mon.reg_c, in_mon.immediate));
      end
      if (res_mon.valid && res_mon.ready) begin
        if (retire_q.size() == 0) begin
          $error("result item with no instruction outstanding");
          mismatch_cnt++;
        end else begin
          exp_r = retire_q.pop_front();
          compare_field("next_pc", exp_r.next_pc, res_mon.next_pc);
          compare_field("write_enable", 16'(exp_r.we), 16'(res_mon.write_enable));
          compare_field("write_index", 16'(exp_r.widx), 16'(res_mon.write_index));
          compare_field("write_value", exp_r.wval, res_mon.write_value);
          compare_field("status", 16'(exp_r.status), 16'(res_mon.status));
        end
      end
    end
  end

endmodule

@@ test/testbench.sv @@
// Stimulus and verdict for the 16-bit instruction execute unit.
`timescale 1ns / 1ps

module testbench;
  import r16ie_pkg::*;

  localparam int unsigned MEM_WORDS  = 1024;
  localparam int unsigned RAND_ITEMS = 1300;
  // the limit covers the clearing pass after reset and leaves a wide margin over
  // RAND_ITEMS random items plus the directed ones, under the heaviest stalls
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // command codes the block decodes as no-ops
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 4'd10;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 4'd15;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned cycle_cnt = 0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rand_sent;

  r16ie_in_if  in_if ();
  r16ie_out_if res_if ();

  risc16_instruction_execute #(
    .MEM_WORDS(MEM_WORDS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .res_o (res_if)
  );

  r16ie_exec_checker #(
    .MEM_WORDS(MEM_WORDS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_if),
    .res_mon       (res_if),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending_cnt)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Result side: ready drops at random according to the current phase.
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog: a hung handshake or lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Present one instruction and hold it until the block takes it. The idle gap comes
  // first, so valid is never lowered and raised in the same step between items.
  task automatic send_insn(logic [CMD_W-1:0] cmd, logic [RIDX_W-1:0] ra,
                           logic [RIDX_W-1:0] rb, logic [RIDX_W-1:0] rc,
                           logic [WORD_W-1:0] imm);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= cmd;
    in_if.reg_a     <= ra;
    in_if.reg_b     <= rb;
    in_if.reg_c     <= rc;
    in_if.immediate <= imm;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  function automatic logic [RIDX_W-1:0] any_reg();
    return RIDX_W'($urandom_range(0, NUM_REGS - 1));
  endfunction

  // Mostly well-formed short programs: load a base register, then hit memory through it,
  // or set up two registers and branch on them. The rest is unconstrained noise.
  task automatic send_random_insn();
    int unsigned       kind;
    int unsigned       n_ops;
    logic [RIDX_W-1:0] base_r, cmp_r;
    logic [WORD_W-1:0] base, val;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      base_r = any_reg();
      case ($urandom_range(0, 3))
        0, 1:    base = WORD_W'($urandom_range(0, 31));             // small window: loads hit stores
        2:       base = WORD_W'($urandom_range(0, MEM_WORDS - 1));
        default: base = WORD_W'($urandom_range(MEM_WORDS - 8, MEM_WORDS + 8)); // top edge
      endcase
      send_insn(CMD_MOVI, base_r, any_reg(), any_reg(), base);
      n_ops = $urandom_range(1, 3);
      for (int i = 0; i < n_ops; i++) begin
        send_insn(($urandom_range(0, 1) == 0) ? CMD_SW : CMD_LW, any_reg(), base_r,
                  any_reg(), WORD_W'(int'($urandom_range(0, 15)) - 8));
      end
      rand_sent += n_ops + 1;
    end else if (kind < 60) begin
      base_r = any_reg();
      cmp_r  = any_reg();
      val    = WORD_W'($urandom_range(0, 65535));
      send_insn(CMD_MOVI, base_r, any_reg(), any_reg(), val);
      send_insn(CMD_MOVI, cmp_r, any_reg(), any_reg(),
                ($urandom_range(0, 1) == 0) ? val : val ^ WORD_W'(1 << $urandom_range(0, 15)));
      send_insn(CMD_BEQ, base_r, cmp_r, any_reg(), WORD_W'($urandom_range(0, 65535)));
      rand_sent += 3;
    end else begin
      send_insn(($urandom_range(0, 19) == 0)
                  ? CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST))
                  : CMD_W'($urandom_range(CMD_ADD, CMD_MOVI)),
                any_reg(), any_reg(), any_reg(), WORD_W'($urandom_range(0, 65535)));
      rand_sent++;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    rand_sent       = 0;
    tx_idle_pct     = 36;
    rx_idle_pct     = 70;
    in_if.valid     <= 1'b0;
    in_if.cmd       <= CMD_NOP;
    in_if.reg_a     <= '0;
    in_if.reg_b     <= '0;
    in_if.reg_c     <= '0;
    in_if.immediate <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: operand extremes, wrapping arithmetic, memory bounds, branch both ways,
    // jump with link onto the top of the PC range, and unused opcodes.
    send_insn(CMD_MOVI, 3'd1, 3'd0, 3'd0, 16'hFFFF);
    send_insn(CMD_MOVI, 3'd2, 3'd7, 3'd7, 16'h8000);
    send_insn(CMD_MOVI, 3'd3, 3'd0, 3'd0, 16'h7FFF);
    send_insn(CMD_ADD,  3'd4, 3'd1, 3'd3, 16'h0000);     // wraps
    send_insn(CMD_ADDI, 3'd5, 3'd2, 3'd0, 16'hFFFF);     // 0x8000 - 1
    send_insn(CMD_NAND, 3'd6, 3'd1, 3'd3, 16'hFFFF);     // bitwise, not logical
    send_insn(CMD_LUI,  3'd7, 3'd0, 3'd0, 16'hFFFF);     // low six bits dropped
    send_insn(CMD_NOP,  3'd7, 3'd7, 3'd7, 16'hFFFF);     // clears r0 whatever the fields
    send_insn(CMD_SW,   3'd3, 3'd0, 3'd0, 16'(MEM_WORDS - 1));  // last word in range
    send_insn(CMD_LW,   3'd4, 3'd0, 3'd0, 16'(MEM_WORDS - 1));
    send_insn(CMD_SW,   3'd1, 3'd0, 3'd0, 16'(MEM_WORDS));      // first word out of range
    send_insn(CMD_LW,   3'd4, 3'd0, 3'd0, 16'(MEM_WORDS));      // no register write
    send_insn(CMD_SW,   3'd3, 3'd1, 3'd0, 16'h0001);     // base + imm wraps to 0
    send_insn(CMD_LW,   3'd5, 3'd1, 3'd0, 16'h0001);
    send_insn(CMD_LW,   3'd6, 3'd3, 3'd0, 16'h7FFF);     // far out of range
    send_insn(CMD_BEQ,  3'd1, 3'd1, 3'd0, 16'hFFFF);     // taken, lands on itself
    send_insn(CMD_BEQ,  3'd1, 3'd2, 3'd0, 16'h0005);     // differ: falls through
    send_insn(CMD_JALR, 3'd6, 3'd1, 3'd0, 16'h0000);     // pc -> 0xFFFF
    send_insn(CMD_ADD,  3'd7, 3'd6, 3'd6, 16'h0000);     // pc + 1 wraps to 0
    send_insn(CMD_BEQ,  3'd0, 3'd0, 3'd0, 16'h8000);     // target wraps backward
    send_insn(CMD_JALR, 3'd3, 3'd3, 3'd0, 16'h0000);     // same reg: target read before link
    send_insn(CMD_UNUSED_FIRST, 3'd1, 3'd2, 3'd3, 16'hFFFF);
    send_insn(CMD_UNUSED_LAST,  3'd7, 3'd7, 3'd7, 16'h0000);
    send_insn(CMD_MOVI, 3'd5, 3'd2, 3'd5, 16'h0000);

    // pressure point: let the pipe empty completely before random traffic
    wait_drained();

    // Three idling regimes: slow receiver, then slow sender, then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 36; rx_idle_pct = 70;
        end
        1: begin
          tx_idle_pct = 70; rx_idle_pct = 36;
        end
        default: begin
          tx_idle_pct = 0;  rx_idle_pct = 0;
        end
      endcase
      while (rand_sent < (phase + 1) * RAND_ITEMS / 3) send_random_insn();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/r16ie_pkg.sv
rtl/r16ie_in_if.sv
rtl/r16ie_out_if.sv
rtl/risc16_instruction_execute.sv
test/r16ie_exec_checker.sv
test/testbench.sv
